// ===== rtl/aba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aba_pkg
// Shared types and constants of the aligned block bitmap allocator.
// ----------------------------------------------------------------------------
package aba_pkg;

	localparam int WORD_W     = 16;
	localparam int WORD_LOG   = 4;
	localparam int ORD_W      = 4;
	localparam int ORD_MAX    = 12;
	localparam int MCE_W      = 5;
	localparam int POOL_W     = 6;
	localparam int POOL_MAX   = 32;
	localparam int SIZE_W     = 32;
	localparam int ADDR_W     = 33;
	localparam int STATUS_W   = 2;
	localparam int CFG_W      = 32;
	localparam int PADDR_W    = 3;
	localparam int MCE_RESET  = 4;
	localparam int POOL_RESET = 12;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_BAD      = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTALLOC = 2'd3
	} st_t;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic {
		REG_MCE  = 1'b0,
		REG_POOL = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_ORDER,
		S_SCAN,
		S_CHECK,
		S_APPLY,
		S_DONE
	} state_t;

	typedef struct packed {
		logic              ok;
		logic [MCE_W-1:0]  mce;
		logic [POOL_W-1:0] pool;
		logic [ORD_W-1:0]  cell_log;
	} cfg_t;

	typedef struct packed {
		st_t               status;
		logic [ADDR_W-1:0] offset;
		logic [ORD_W-1:0]  order;
	} res_t;

endpackage

// ===== rtl/aba_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aba_req_if
// Request channel: allocate or free, with valid/ready handshake.
// ----------------------------------------------------------------------------
interface aba_req_if import aba_pkg::*; ();

	logic              valid;
	logic              ready;
	logic              opcode;
	logic [SIZE_W-1:0] request_size;
	logic [ADDR_W-1:0] release_address;

	modport source (
		output valid, opcode, request_size, release_address,
		input  ready
	);

	modport sink (
		input  valid, opcode, request_size, release_address,
		output ready
	);

endinterface

// ===== rtl/aba_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aba_rsp_if
// Response channel: status, block offset and order, with valid/ready handshake.
// ----------------------------------------------------------------------------
interface aba_rsp_if import aba_pkg::*; ();

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [ADDR_W-1:0]   block_offset;
	logic [ORD_W-1:0]    block_order;

	modport source (
		output valid, status, block_offset, block_order,
		input  ready
	);

	modport sink (
		input  valid, status, block_offset, block_order,
		output ready
	);

endinterface

// ===== rtl/aba_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aba_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module aba_ram #(
	parameter int  WIDTH = 16,
	parameter int  DEPTH = 16,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/aba_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aba_cfg
// APB register file for cell and pool exponents, with configuration check.
// ----------------------------------------------------------------------------
module aba_cfg import aba_pkg::*; #(
	parameter int MAX_CELLS = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [CFG_W-1:0]   pwdata,
	output logic [CFG_W-1:0]   prdata,
	output logic               pready,
	output cfg_t               cfg
);

	localparam int MAX_LOG = $clog2(MAX_CELLS + 1) - 1;

	logic [MCE_W-1:0]  mce_q;
	logic [POOL_W-1:0] pool_q;
	logic [POOL_W-1:0] diff;
	logic              wr;
	reg_idx_t          idx;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[PADDR_W-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mce_q  <= MCE_W'(MCE_RESET);
			pool_q <= POOL_W'(POOL_RESET);
		end else if (wr) begin
			unique case (idx)
				REG_MCE:  mce_q  <= pwdata[MCE_W-1:0];
				REG_POOL: pool_q <= pwdata[POOL_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_MCE:  prdata = CFG_W'(mce_q);
			REG_POOL: prdata = CFG_W'(pool_q);
		endcase
	end

	always_comb begin
		diff         = pool_q - POOL_W'(mce_q);
		cfg.mce      = mce_q;
		cfg.pool     = pool_q;
		cfg.cell_log = diff[ORD_W-1:0];
		cfg.ok       = (mce_q != '0) && (pool_q <= POOL_W'(POOL_MAX))
			&& (pool_q > POOL_W'(mce_q)) && (diff <= POOL_W'(MAX_LOG))
			&& (diff <= POOL_W'(ORD_MAX));
	end

endmodule

// ===== rtl/aba_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aba_ctrl
// Request sequencer: decode, used-map word scan, check and mark/clear passes.
// ----------------------------------------------------------------------------
module aba_ctrl import aba_pkg::*; #(
	parameter int  MAX_CELLS = 256,
	localparam int CW        = $clog2(MAX_CELLS),
	localparam int NWORDS    = (MAX_CELLS + WORD_W - 1) / WORD_W,
	localparam int AW        = (NWORDS > 1) ? $clog2(NWORDS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	aba_req_if.sink           req,
	aba_rsp_if.source         rsp,
	output logic              u_we,
	output logic [AW-1:0]     u_waddr,
	output logic [WORD_W-1:0] u_wdata,
	output logic              u_re,
	output logic [AW-1:0]     u_raddr,
	input  logic [WORD_W-1:0] u_rdata,
	output logic              o_we,
	output logic [CW-1:0]     o_waddr,
	output logic [ORD_W-1:0]  o_wdata,
	output logic              o_re,
	output logic [CW-1:0]     o_raddr,
	input  logic [ORD_W-1:0]  o_rdata
);

	localparam int CNT_W = $clog2(MAX_CELLS + 1);
	localparam int WC_W  = $clog2(NWORDS + 1);
	localparam int XW    = CNT_W + WORD_LOG;

	state_t            state_q, state_d;
	logic [CW-1:0]     clr_q;
	op_t               op_q;
	logic [SIZE_W-1:0] size_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ORD_W-1:0]  k_q;
	logic [CNT_W-1:0]  base_q, hi_q;
	logic [WC_W-1:0]   rd_q;
	logic [AW-1:0]     wend_q;
	logic              vld_s1;
	logic [AW-1:0]     w_s1;
	logic              grp_ok_q, chk_ok_q;
	res_t              res_q, out_q;
	logic              out_vld_q;

	// datapath terms
	logic [CNT_W-1:0]    ncell, len;
	logic [ADDR_W-1:0]   off, off_sh;
	logic                size_bad, addr_bad;
	logic [SIZE_W-1:0]   size_sh;
	logic [ORD_W-1:0]    k_new;
	logic [CNT_W-1:0]    cell_c;
	logic [CNT_W:0]      ord_len, sum;
	logic [XW-1:0]       pos_base, scan_cell, scan_end;
	logic [WORD_W-1:0]   lenmask, cand, mask;
	logic                found_small;
	logic [WORD_LOG-1:0] jsel;
	logic                big;
	logic [ORD_W-1:0]    gsh;
	logic [AW-1:0]       gmask, wpos;
	logic                grp_ok, scan_found, last, chk_word_ok;

	// control terms
	logic pass_end, rd_en, out_load, pass_st;

	always_comb begin
		ncell    = CNT_W'(1) << cfg.cell_log;
		len      = CNT_W'(1) << k_q;
		off      = addr_q - ADDR_W'(1);
		size_bad = (size_q == '0) || ((ADDR_W'(size_q) >> cfg.pool) != '0);
		addr_bad = (addr_q == '0) || ((off >> cfg.pool) != '0);
		size_sh  = size_q >> cfg.mce;
		k_new    = '0;
		for (int b = 0; b < ORD_MAX; b++) begin
			if (size_sh[b]) begin
				k_new = ORD_W'(b + 1);
			end
		end
		off_sh  = off >> cfg.mce;
		cell_c  = off_sh[CNT_W-1:0];
		ord_len = (CNT_W + 1)'(1) << o_rdata;
		sum     = (CNT_W + 1)'(base_q) + ord_len;

		// word evaluation
		pos_base = XW'(w_s1) << WORD_LOG;
		lenmask  = ~({WORD_W{1'b1}} << len);
		for (int j = 0; j < WORD_W; j++) begin
			cand[j] = ((WORD_LOG'(j) & WORD_LOG'(len - CNT_W'(1))) == '0)
				&& ((pos_base + XW'(j) + XW'(len)) <= XW'(ncell))
				&& (((u_rdata >> j) & lenmask) == '0);
		end
		found_small = 1'b0;
		jsel        = '0;
		for (int j = WORD_W - 1; j >= 0; j--) begin
			if (cand[j]) begin
				found_small = 1'b1;
				jsel        = WORD_LOG'(j);
			end
		end
		big        = k_q > ORD_W'(WORD_LOG);
		gsh        = k_q - ORD_W'(WORD_LOG);
		gmask      = AW'(((AW + 1)'(1) << gsh) - (AW + 1)'(1));
		wpos       = w_s1 & gmask;
		grp_ok     = (u_rdata == '0) && ((wpos == '0) || grp_ok_q);
		scan_found = big ? (grp_ok && (wpos == gmask)) : found_small;
		scan_cell  = big ? (XW'(w_s1 & ~gmask) << WORD_LOG) : (pos_base + XW'(jsel));
		scan_end   = scan_cell + XW'(len) - XW'(1);
		for (int b = 0; b < WORD_W; b++) begin
			mask[b] = ((pos_base + XW'(b)) >= XW'(base_q))
				&& ((pos_base + XW'(b)) < XW'(hi_q));
		end
		chk_word_ok = (u_rdata & mask) == mask;
		last        = w_s1 == wend_q;
	end

	// next state and outputs
	always_comb begin
		state_d  = state_q;
		pass_end = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == CW'(MAX_CELLS - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req.valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				if (!cfg.ok) begin
					state_d = S_DONE;
				end else if (op_q == OP_ALLOC) begin
					state_d = size_bad ? S_DONE : S_SCAN;
				end else begin
					state_d = addr_bad ? S_DONE : S_ORDER;
				end
			end
			S_ORDER: begin
				if ((o_rdata > cfg.cell_log) || (sum > (CNT_W + 1)'(ncell))) begin
					state_d = S_DONE;
				end else begin
					state_d = S_CHECK;
				end
			end
			S_SCAN: begin
				if (vld_s1 && (scan_found || last)) begin
					pass_end = 1'b1;
					state_d  = scan_found ? S_APPLY : S_DONE;
				end
			end
			S_CHECK: begin
				if (vld_s1 && last) begin
					pass_end = 1'b1;
					state_d  = (chk_ok_q && chk_word_ok) ? S_APPLY : S_DONE;
				end
			end
			S_APPLY: begin
				if (vld_s1 && last) begin
					pass_end = 1'b1;
					state_d  = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_vld_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
		endcase

		pass_st = (state_q == S_SCAN) || (state_q == S_CHECK) || (state_q == S_APPLY);
		rd_en   = pass_st && (rd_q <= WC_W'(wend_q)) && !pass_end;

		u_re    = rd_en;
		u_raddr = AW'(rd_q);
		u_we    = ((state_q == S_CLEAR) && ((CW + 1)'(clr_q) < (CW + 1)'(NWORDS)))
			|| ((state_q == S_APPLY) && vld_s1);
		u_waddr = (state_q == S_CLEAR) ? AW'(clr_q) : w_s1;
		if (state_q == S_CLEAR) begin
			u_wdata = '0;
		end else if (op_q == OP_ALLOC) begin
			u_wdata = u_rdata | mask;
		end else begin
			u_wdata = u_rdata & ~mask;
		end

		o_we    = (state_q == S_CLEAR) || ((state_q == S_SCAN) && vld_s1 && scan_found);
		o_waddr = (state_q == S_CLEAR) ? clr_q : (CW'(scan_cell) & CW'(MAX_CELLS - 1));
		o_wdata = (state_q == S_CLEAR) ? '0 : k_q;
		o_re    = (state_q == S_DECODE) && (op_q == OP_FREE);
		o_raddr = CW'(cell_c);

		req.ready = state_q == S_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= rd_en;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + CW'(1);
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		w_s1 <= AW'(rd_q);
		if (rd_en) begin
			rd_q <= rd_q + WC_W'(1);
		end
		if (out_load) begin
			out_q <= res_q;
		end
		unique case (state_q)
			S_IDLE: begin
				op_q   <= op_t'(req.opcode);
				size_q <= req.request_size;
				addr_q <= req.release_address;
			end
			S_DECODE: begin
				res_q    <= '{status: ST_BAD, offset: '0, order: '0};
				k_q      <= k_new;
				base_q   <= cell_c;
				rd_q     <= '0;
				wend_q   <= AW'((ncell - CNT_W'(1)) >> WORD_LOG);
				grp_ok_q <= 1'b0;
			end
			S_ORDER: begin
				k_q      <= o_rdata;
				hi_q     <= sum[CNT_W-1:0];
				wend_q   <= AW'((sum - (CNT_W + 1)'(1)) >> WORD_LOG);
				rd_q     <= WC_W'(base_q >> WORD_LOG);
				chk_ok_q <= 1'b1;
				res_q.status <= (o_rdata > cfg.cell_log) ? ST_BAD : ST_NOTALLOC;
			end
			S_SCAN: begin
				if (vld_s1) begin
					grp_ok_q     <= grp_ok;
					res_q.status <= ST_FULL;
					if (scan_found) begin
						base_q <= CNT_W'(scan_cell);
						hi_q   <= CNT_W'(scan_cell) + len;
						wend_q <= AW'(scan_end >> WORD_LOG);
						rd_q   <= WC_W'(scan_cell >> WORD_LOG);
					end
				end
			end
			S_CHECK: begin
				if (vld_s1) begin
					chk_ok_q <= chk_ok_q && chk_word_ok;
					if (last) begin
						rd_q         <= WC_W'(base_q >> WORD_LOG);
						res_q.status <= ST_NOTALLOC;
					end
				end
			end
			S_APPLY: begin
				if (vld_s1 && last) begin
					res_q.status <= ST_OK;
					res_q.order  <= k_q;
					res_q.offset <= (op_q == OP_ALLOC)
						? ((ADDR_W'(base_q) << cfg.mce) + ADDR_W'(1)) : '0;
				end
			end
			S_CLEAR, S_DONE: begin
			end
		endcase
	end

	assign rsp.valid        = out_vld_q;
	assign rsp.status       = out_q.status;
	assign rsp.block_offset = out_q.offset;
	assign rsp.block_order  = out_q.order;

endmodule

// ===== rtl/aligned_block_bitmap_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aligned_block_bitmap_allocator
// Power-of-two aligned block allocator over a used-cell bitmap in RAM.
// ----------------------------------------------------------------------------
// req: one allocate or free per transfer, taken only while no request is
//   being worked on. rsp: one result per request, held in an output
//   register, so the next request is taken while a result still waits.
// apb: min_cell_exponent at 0x0, pool_exponent at 0x4. These are to be
//   written only when idle; the block itself does not enforce this.
// The used map is kept in 16-cell words, one word read per cycle.
// Allocate: decode, then scan words until the first free aligned run
//   (up to MAX_CELLS/16 words), then mark the words of the block.
// Free: decode, read the block order, then check and then clear each word
//   the block touches.
// After reset a clearing pass zeroes both RAMs; req is not ready until it
//   ends. A stalled rsp holds its result; the block finishes at most one
//   further request and then waits.
// ----------------------------------------------------------------------------
module aligned_block_bitmap_allocator import aba_pkg::*; #(
	parameter int  MAX_CELLS = 256,
	localparam int CW        = $clog2(MAX_CELLS),
	localparam int NWORDS    = (MAX_CELLS + WORD_W - 1) / WORD_W,
	localparam int AW        = (NWORDS > 1) ? $clog2(NWORDS) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	aba_req_if.sink            req,
	aba_rsp_if.source          rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [CFG_W-1:0]   pwdata,
	output logic [CFG_W-1:0]   prdata,
	output logic               pready
);

	cfg_t              cfg;
	logic              u_we, u_re;
	logic [AW-1:0]     u_waddr, u_raddr;
	logic [WORD_W-1:0] u_wdata, u_rdata;
	logic              o_we, o_re;
	logic [CW-1:0]     o_waddr, o_raddr;
	logic [ORD_W-1:0]  o_wdata, o_rdata;

	aba_cfg #(
		.MAX_CELLS (MAX_CELLS)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	aba_ram #(
		.WIDTH (WORD_W),
		.DEPTH (NWORDS)
	) u_used_ram (
		.clk   (clk),
		.we    (u_we),
		.waddr (u_waddr),
		.wdata (u_wdata),
		.re    (u_re),
		.raddr (u_raddr),
		.rdata (u_rdata)
	);

	aba_ram #(
		.WIDTH (ORD_W),
		.DEPTH (MAX_CELLS)
	) u_order_ram (
		.clk   (clk),
		.we    (o_we),
		.waddr (o_waddr),
		.wdata (o_wdata),
		.re    (o_re),
		.raddr (o_raddr),
		.rdata (o_rdata)
	);

	aba_ctrl #(
		.MAX_CELLS (MAX_CELLS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.req     (req),
		.rsp     (rsp),
		.u_we    (u_we),
		.u_waddr (u_waddr),
		.u_wdata (u_wdata),
		.u_re    (u_re),
		.u_raddr (u_raddr),
		.u_rdata (u_rdata),
		.o_we    (o_we),
		.o_waddr (o_waddr),
		.o_wdata (o_wdata),
		.o_re    (o_re),
		.o_raddr (o_raddr),
		.o_rdata (o_rdata)
	);

`ifndef SYNTHESIS
	a_used_no_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(u_we && u_re && (u_waddr == u_raddr)))
		else $error("used map read and write collide on one word");

	a_order_wr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		o_we |-> !req.ready)
		else $error("order table written while requests are taken");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status != ST_OK)) |->
		((rsp.block_offset == '0) && (rsp.block_order == '0)))
		else $error("failed request returns a nonzero offset or order");
`endif

endmodule
